FILE: rtl/core/sfpc_pkg.sv
// Shared types and constants of the stepper focus position controller.
package sfpc_pkg;

  localparam int unsigned PosBits = 16;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);
  localparam logic [PosBits-1:0] NudgeSteps = PosBits'(5);
  localparam logic [PosBits-1:0] NudgeDownFloor = PosBits'(4);
  localparam logic [7:0] RampDecrement = 8'd2;

  localparam logic [7:0] SlowStepReset = 8'd20;
  localparam logic [7:0] FastStepReset = 8'd4;
  localparam logic [15:0] ChunkStepsReset = 16'd100;
  localparam logic [15:0] DisableDelayReset = 16'd2000;
  localparam logic [15:0] RezeroPosReset = 16'd1000;

  typedef enum logic [2:0] {
    ActSetTarget = 3'd0,
    ActStop      = 3'd1,
    ActGo        = 3'd2,
    ActRezero    = 3'd3,
    ActNudgeUp   = 3'd4,
    ActNudgeDown = 3'd5,
    ActTick      = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    RegSlowStep     = 3'd0,
    RegFastStep     = 3'd1,
    RegChunkSteps   = 3'd2,
    RegDisableDelay = 3'd3,
    RegRezeroPos    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic        step_level;
    logic        direction_up;
    logic        driver_disabled;
    logic [15:0] position;
    logic        report_valid;
    logic        moving;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  slow_step_ms;
    logic [7:0]  fast_step_ms;
    logic [15:0] chunk_steps;
    logic [15:0] disable_delay_ticks;
    logic [15:0] rezero_position;
  } cfg_t;

endpackage

FILE: rtl/core/sfpc_cfg_regs.sv
// Configuration register file of the stepper focus position controller.
module sfpc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [2:0]        wr_index_i,
  input  logic [15:0]       wr_data_i,
  output sfpc_pkg::cfg_t    cfg_o
);

  sfpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        sfpc_pkg::RegSlowStep:     cfg_d.slow_step_ms        = wr_data_i[7:0];
        sfpc_pkg::RegFastStep:     cfg_d.fast_step_ms        = wr_data_i[7:0];
        sfpc_pkg::RegChunkSteps:   cfg_d.chunk_steps         = wr_data_i;
        sfpc_pkg::RegDisableDelay: cfg_d.disable_delay_ticks = wr_data_i;
        sfpc_pkg::RegRezeroPos:    cfg_d.rezero_position     = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_step_ms        <= sfpc_pkg::SlowStepReset;
      cfg_q.fast_step_ms        <= sfpc_pkg::FastStepReset;
      cfg_q.chunk_steps         <= sfpc_pkg::ChunkStepsReset;
      cfg_q.disable_delay_ticks <= sfpc_pkg::DisableDelayReset;
      cfg_q.rezero_position     <= sfpc_pkg::RezeroPosReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/sfpc_core.sv
// Motion state and single-pass update for one command or tick.
module sfpc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  sfpc_pkg::in_item_t  item_i,
  input  sfpc_pkg::cfg_t      cfg_i,
  output sfpc_pkg::out_item_t result_o
);

  typedef struct packed {
    logic [sfpc_pkg::PosBits-1:0] current_pos;
    logic [sfpc_pkg::PosBits-1:0] goal_pos;
    logic [15:0]                  steps_remaining;
    logic                         dir_up;
    logic                         active;
    logic [7:0]                   half_period;
    logic [7:0]                   ms_count;
    logic                         pin_high;
    logic [15:0]                  chunk_count;
    logic [15:0]                  idle_count;
    logic                         idle_armed;
    logic                         disabled;
  } st_t;

  st_t  st_q, st_d;
  logic report;
  logic do_aim;
  logic step_start;
  logic [7:0] phase_len;

  always_comb begin
    st_d       = st_q;
    report     = 1'b0;
    do_aim     = 1'b0;
    step_start = 1'b0;
    phase_len  = (st_q.half_period == 8'd0) ? 8'd1 : st_q.half_period;

    case (item_i.action)
      sfpc_pkg::ActSetTarget: begin
        st_d.goal_pos = item_i.target_position;
        do_aim        = 1'b1;
      end
      sfpc_pkg::ActStop: begin
        st_d.goal_pos        = st_q.current_pos;
        st_d.steps_remaining = '0;
        st_d.active          = 1'b0;
        st_d.pin_high        = 1'b0;
        st_d.ms_count        = '0;
        st_d.disabled        = 1'b1;
        st_d.idle_armed      = 1'b0;
      end
      sfpc_pkg::ActGo: begin
        st_d.active      = 1'b1;
        st_d.disabled    = 1'b0;
        st_d.half_period = cfg_i.slow_step_ms;
      end
      sfpc_pkg::ActRezero: begin
        st_d.active      = 1'b1;
        st_d.current_pos = cfg_i.rezero_position;
        st_d.goal_pos    = '0;
        st_d.half_period = cfg_i.slow_step_ms;
        do_aim           = 1'b1;
      end
      sfpc_pkg::ActNudgeUp: begin
        st_d.active   = 1'b1;
        st_d.goal_pos = (st_q.current_pos > sfpc_pkg::PosMax - sfpc_pkg::NudgeSteps) ?
                        sfpc_pkg::PosMax : st_q.current_pos + sfpc_pkg::NudgeSteps;
        do_aim        = 1'b1;
      end
      sfpc_pkg::ActNudgeDown: begin
        st_d.active = 1'b1;
        if (st_q.current_pos > sfpc_pkg::NudgeDownFloor) begin
          st_d.goal_pos = st_q.current_pos - sfpc_pkg::NudgeSteps;
        end
        do_aim = 1'b1;
      end
      sfpc_pkg::ActTick: begin
        if (st_q.idle_armed) begin
          st_d.idle_count = st_q.idle_count + 16'd1;
          if (st_d.idle_count >= cfg_i.disable_delay_ticks) begin
            st_d.disabled   = 1'b1;
            st_d.idle_armed = 1'b0;
          end
        end
        if (st_q.active) begin
          step_start = !st_q.pin_high && (st_q.ms_count == 8'd0);
          if (step_start && (st_q.steps_remaining == 16'd0)) begin
            // Arrival: report once and start the disable countdown, or disable at once if the delay is zero.
            st_d.active      = 1'b0;
            st_d.chunk_count = '0;
            report           = 1'b1;
            st_d.idle_count  = '0;
            if (cfg_i.disable_delay_ticks == 16'd0) begin
              st_d.disabled   = 1'b1;
              st_d.idle_armed = 1'b0;
            end else begin
              st_d.idle_armed = 1'b1;
            end
          end else begin
            if (step_start) begin
              st_d.pin_high = 1'b1;
              st_d.ms_count = phase_len;
            end
            st_d.ms_count = st_d.ms_count - 8'd1;
            if (st_d.ms_count == 8'd0) begin
              if (st_d.pin_high) begin
                st_d.pin_high = 1'b0;
                st_d.ms_count = phase_len;
              end else if (st_q.steps_remaining != 16'd0) begin
                // End of the low phase completes the step.
                st_d.current_pos     = st_q.dir_up ? st_q.current_pos + sfpc_pkg::PosOne
                                                   : st_q.current_pos - sfpc_pkg::PosOne;
                st_d.steps_remaining = st_q.steps_remaining - 16'd1;
                st_d.chunk_count     = st_q.chunk_count + 16'd1;
                if ((st_d.chunk_count >= cfg_i.chunk_steps) ||
                    (st_d.steps_remaining == 16'd0)) begin
                  report           = 1'b1;
                  st_d.chunk_count = '0;
                end
                if (st_q.half_period > cfg_i.fast_step_ms) begin
                  st_d.half_period = (st_q.half_period > sfpc_pkg::RampDecrement) ?
                                     st_q.half_period - sfpc_pkg::RampDecrement : 8'd1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (do_aim) begin
      st_d.disabled   = 1'b0;
      st_d.idle_armed = 1'b0;
      if (st_d.goal_pos > st_d.current_pos) begin
        st_d.dir_up          = 1'b1;
        st_d.steps_remaining = 16'(st_d.goal_pos - st_d.current_pos);
      end else begin
        st_d.dir_up          = 1'b0;
        st_d.steps_remaining = 16'(st_d.current_pos - st_d.goal_pos);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.current_pos     <= '0;
      st_q.goal_pos        <= '0;
      st_q.steps_remaining <= '0;
      st_q.dir_up          <= 1'b0;
      st_q.active          <= 1'b0;
      st_q.half_period     <= sfpc_pkg::SlowStepReset;
      st_q.ms_count        <= '0;
      st_q.pin_high        <= 1'b0;
      st_q.chunk_count     <= '0;
      st_q.idle_count      <= '0;
      st_q.idle_armed      <= 1'b0;
      st_q.disabled        <= 1'b1;
    end else if (step_en_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    result_o.step_level      = st_d.pin_high;
    result_o.direction_up    = st_d.dir_up;
    result_o.driver_disabled = st_d.disabled;
    result_o.position        = st_d.current_pos;
    result_o.report_valid    = report;
    result_o.moving          = st_d.active;
  end

endmodule

FILE: rtl/core/stepper_focus_position_controller_unit.sv
// Top level of the stepper focus position controller.
//
//   channel  signals                                    direction
//   in       in_valid_i, in_stall_o, in_data_i          command or tick in
//   out      out_valid_o, out_stall_i, out_data_o       one status item out
//   cfg      cfg_valid_i, cfg_ready_o, cfg_index_i/data   register write in
//
// An item is registered on input, updated in one pass and its status lands in
// the output register; one item per cycle is sustained while the output is not
// stalled.
// Reset restores the register defaults, stops the motor and disables the driver.
// A stall on a full output register holds both stages; the input stalls only when full.
// Configuration writes are always taken.
module stepper_focus_position_controller_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfpc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfpc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic                in_valid_q;
  sfpc_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  sfpc_pkg::out_item_t out_item_q;
  sfpc_pkg::out_item_t result;
  sfpc_pkg::cfg_t      cfg;
  logic                advance;
  logic                in_free;

  assign cfg_ready_o = 1'b1;

  sfpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The input stage moves on when the output register is empty or being drained.
  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_free = !in_valid_q || advance;
  assign in_stall_o = !in_free;

  sfpc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

FILE: tb/sv/stepper_focus_position_controller_unit_tb.sv
// Self-checking testbench for the stepper focus position controller unit.
`timescale 1ns / 100ps

module stepper_focus_position_controller_unit_tb;

  localparam logic [2:0] ActUnused = 3'd7;
  localparam int unsigned ItemTarget = 1150;
  localparam int unsigned QuietLimit = 1000;

  typedef struct {
    bit                  is_cfg;
    sfpc_pkg::cfg_t      cfg;
    sfpc_pkg::in_item_t  cmd;
    bit                  fixed;
    sfpc_pkg::out_item_t want;
  } focus_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  sfpc_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sfpc_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i = '0;

  // Predicted controller state and register copy.
  sfpc_pkg::cfg_t m_cfg;
  logic [15:0]    m_pos, m_goal, m_left, m_chunk, m_idle;
  logic [7:0]     m_half, m_ms;
  logic           m_up, m_run, m_pin, m_armed, m_off;

  sfpc_pkg::out_item_t pending_status[$];
  int unsigned mismatches = 0;
  int unsigned cmds_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  stepper_focus_position_controller_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void aim_motor();
    m_off = 1'b0;
    m_armed = 1'b0;
    m_up = m_goal > m_pos;
    m_left = m_up ? m_goal - m_pos : m_pos - m_goal;
  endfunction

  function automatic logic tick_motor();
    logic [7:0] phase;
    logic       rep;
    phase = (m_half == 8'd0) ? 8'd1 : m_half;
    rep = 1'b0;
    if (m_armed) begin
      m_idle = m_idle + 16'd1;
      if (m_idle >= m_cfg.disable_delay_ticks) begin
        m_off = 1'b1;
        m_armed = 1'b0;
      end
    end
    if (!m_run) return 1'b0;
    if (!m_pin && m_ms == 8'd0) begin
      // Nothing left to do: this tick is the arrival.
      if (m_left == 16'd0) begin
        m_run = 1'b0;
        m_chunk = 16'd0;
        m_idle = 16'd0;
        if (m_cfg.disable_delay_ticks == 16'd0) begin
          m_off = 1'b1;
          m_armed = 1'b0;
        end else begin
          m_armed = 1'b1;
        end
        return 1'b1;
      end
      m_pin = 1'b1;
      m_ms = phase;
    end
    m_ms = m_ms - 8'd1;
    if (m_ms == 8'd0) begin
      if (m_pin) begin
        m_pin = 1'b0;
        m_ms = phase;
      end else if (m_left != 16'd0) begin
        // The step lands in whatever direction holds now.
        m_pos = m_up ? m_pos + 16'd1 : m_pos - 16'd1;
        m_left = m_left - 16'd1;
        m_chunk = m_chunk + 16'd1;
        if (m_chunk >= m_cfg.chunk_steps || m_left == 16'd0) begin
          rep = 1'b1;
          m_chunk = 16'd0;
        end
        if (m_half > m_cfg.fast_step_ms)
          m_half = (m_half > sfpc_pkg::RampDecrement) ?
                   m_half - sfpc_pkg::RampDecrement : 8'd1;
      end
    end
    return rep;
  endfunction

  function automatic sfpc_pkg::out_item_t focus_next_status(sfpc_pkg::in_item_t cmd);
    sfpc_pkg::out_item_t st;
    logic                rep;
    rep = 1'b0;
    case (cmd.action)
      sfpc_pkg::ActSetTarget: begin
        m_goal = cmd.target_position;
        aim_motor();
      end
      sfpc_pkg::ActStop: begin
        m_goal = m_pos;
        m_left = 16'd0;
        m_run = 1'b0;
        m_pin = 1'b0;
        m_ms = 8'd0;
        m_off = 1'b1;
        m_armed = 1'b0;
      end
      sfpc_pkg::ActGo: begin
        m_run = 1'b1;
        m_off = 1'b0;
        m_half = m_cfg.slow_step_ms;
      end
      sfpc_pkg::ActRezero: begin
        m_run = 1'b1;
        m_pos = m_cfg.rezero_position;
        m_goal = 16'd0;
        m_half = m_cfg.slow_step_ms;
        aim_motor();
      end
      sfpc_pkg::ActNudgeUp: begin
        m_run = 1'b1;
        m_goal = (m_pos > sfpc_pkg::PosMax - sfpc_pkg::NudgeSteps) ?
                 sfpc_pkg::PosMax : m_pos + sfpc_pkg::NudgeSteps;
        aim_motor();
      end
      sfpc_pkg::ActNudgeDown: begin
        m_run = 1'b1;
        if (m_pos > sfpc_pkg::NudgeDownFloor) m_goal = m_pos - sfpc_pkg::NudgeSteps;
        aim_motor();
      end
      sfpc_pkg::ActTick: rep = tick_motor();
      default: ;
    endcase
    st.step_level = m_pin;
    st.direction_up = m_up;
    st.driver_disabled = m_off;
    st.position = m_pos;
    st.report_valid = rep;
    st.moving = m_run;
    return st;
  endfunction

  function automatic logic [15:0] near_target();
    return m_pos + 16'($urandom_range(0, 24)) - 16'd12;
  endfunction

  function automatic focus_row_t cmd_row(logic [2:0] a, logic [15:0] t, bit fixed,
                                         sfpc_pkg::out_item_t want);
    focus_row_t r;
    r.is_cfg = 1'b0;
    r.cfg = '0;
    r.cmd = '{action: a, target_position: t};
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic focus_row_t cfg_row(sfpc_pkg::cfg_t c);
    focus_row_t r;
    r = cmd_row(ActUnused, 16'd0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.cfg = c;
    return r;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endfunction

  task automatic issue(sfpc_pkg::in_item_t cmd, bit fixed, sfpc_pkg::out_item_t want);
    int unsigned         gap;
    sfpc_pkg::out_item_t status;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    status = focus_next_status(cmd);
    pending_status.push_back(fixed ? want : status);
    cmds_sent++;
  endtask

  task automatic send_command(logic [2:0] a, logic [15:0] t);
    issue('{action: a, target_position: t}, 1'b0, '0);
  endtask

  task automatic write_reg(sfpc_pkg::cfg_reg_e r, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      sfpc_pkg::RegSlowStep:     m_cfg.slow_step_ms = d[7:0];
      sfpc_pkg::RegFastStep:     m_cfg.fast_step_ms = d[7:0];
      sfpc_pkg::RegChunkSteps:   m_cfg.chunk_steps = d;
      sfpc_pkg::RegDisableDelay: m_cfg.disable_delay_ticks = d;
      sfpc_pkg::RegRezeroPos:    m_cfg.rezero_position = d;
      default: ;
    endcase
  endtask

  // Registers change only with the pipeline empty.
  task automatic load_config(sfpc_pkg::cfg_t c);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    // The upper byte of the 8-bit registers carries junk that must be ignored.
    write_reg(sfpc_pkg::RegSlowStep, {8'($urandom), c.slow_step_ms});
    write_reg(sfpc_pkg::RegFastStep, {8'($urandom), c.fast_step_ms});
    write_reg(sfpc_pkg::RegChunkSteps, c.chunk_steps);
    write_reg(sfpc_pkg::RegDisableDelay, c.disable_delay_ticks);
    write_reg(sfpc_pkg::RegRezeroPos, c.rezero_position);
    cfg_valid_i <= 1'b0;
  endtask

  // Ticks until arrival, with the odd command landing mid-step, then a few
  // more ticks so the disable countdown gets exercised.
  task automatic run_ticks();
    int unsigned cap, n, slow_eff;
    slow_eff = (m_cfg.slow_step_ms == 8'd0) ? 1 : m_cfg.slow_step_ms;
    cap = 2 * slow_eff * 14 + 20;
    if (cap > 300) cap = 300;
    n = 0;
    while (n < cap && m_run) begin
      if ($urandom_range(0, 29) == 0)
        send_command(3'($urandom_range(0, 7)), near_target());
      send_command(sfpc_pkg::ActTick, 16'($urandom));
      n++;
    end
    repeat ($urandom_range(0, 25)) send_command(sfpc_pkg::ActTick, 16'($urandom));
  endtask

  always @(posedge clk_i) begin : status_check
    sfpc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: status with no command pending, got %p", $time, out_data_o);
      end else begin
        want = pending_status.pop_front();
        check_field("step_level", 16'(want.step_level), 16'(out_data_o.step_level));
        check_field("direction_up", 16'(want.direction_up), 16'(out_data_o.direction_up));
        check_field("driver_disabled", 16'(want.driver_disabled),
                    16'(out_data_o.driver_disabled));
        check_field("position", want.position, out_data_o.position);
        check_field("report_valid", 16'(want.report_valid), 16'(out_data_o.report_valid));
        check_field("moving", 16'(want.moving), 16'(out_data_o.moving));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("stepper_focus_position_controller_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : status_stall
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    focus_row_t     plan[$];
    sfpc_pkg::cfg_t c;
    int unsigned    phase_end;
    m_cfg = '{sfpc_pkg::SlowStepReset, sfpc_pkg::FastStepReset, sfpc_pkg::ChunkStepsReset,
              sfpc_pkg::DisableDelayReset, sfpc_pkg::RezeroPosReset};
    m_pos = '0;
    m_goal = '0;
    m_left = '0;
    m_chunk = '0;
    m_idle = '0;
    m_half = sfpc_pkg::SlowStepReset;
    m_ms = '0;
    m_up = 1'b0;
    m_run = 1'b0;
    m_pin = 1'b0;
    m_armed = 1'b0;
    m_off = 1'b1;

    // Reset state, the unused code, nudge down near zero, arrival with nothing
    // to do, go and stop.
    plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}));
    plan.push_back(cmd_row(ActUnused, 16'hFFFF, 1'b1,
                           '{1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}));
    plan.push_back(cmd_row(sfpc_pkg::ActNudgeDown, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0}));
    plan.push_back(cmd_row(sfpc_pkg::ActSetTarget, 16'hFFFF, 1'b1,
                           '{1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}));
    plan.push_back(cmd_row(sfpc_pkg::ActGo, 16'h0000, 1'b1,
                           '{1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b1,
                           '{1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActStop, 16'h0000, 1'b1,
                           '{1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0}));
    // Top of range, zero chunk, zero disable delay.
    plan.push_back(cfg_row('{8'd1, 8'd0, 16'd0, 16'd0, 16'hFFFF}));
    plan.push_back(cmd_row(sfpc_pkg::ActRezero, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActNudgeUp, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0}));
    plan.push_back(cmd_row(sfpc_pkg::ActSetTarget, 16'hFFFD, 1'b0, '0));
    plan.push_back(cmd_row(sfpc_pkg::ActGo, 16'h0000, 1'b0, '0));
    repeat (5) plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b0, '0));
    // Zero step time, widest register values.
    plan.push_back(cfg_row('{8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0000}));
    plan.push_back(cmd_row(sfpc_pkg::ActRezero, 16'h0000, 1'b1,
                           '{1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b1}));
    plan.push_back(cmd_row(sfpc_pkg::ActNudgeUp, 16'h0000, 1'b0, '0));
    repeat (2) plan.push_back(cmd_row(sfpc_pkg::ActTick, 16'h0000, 1'b0, '0));
    plan.push_back(cmd_row(sfpc_pkg::ActNudgeDown, 16'h0000, 1'b0, '0));
    plan.push_back(cmd_row(sfpc_pkg::ActStop, 16'h0000, 1'b0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) load_config(plan[i].cfg);
      else issue(plan[i].cmd, plan[i].fixed, plan[i].want);
    end

    while (cmds_sent < ItemTarget) begin
      case ($urandom_range(0, 7))
        0:       c.slow_step_ms = 8'd0;
        1:       c.slow_step_ms = 8'd255;
        2:       c.slow_step_ms = 8'd1;
        default: c.slow_step_ms = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       c.fast_step_ms = 8'd0;
        1:       c.fast_step_ms = 8'd255;
        default: c.fast_step_ms = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0:       c.chunk_steps = 16'd0;
        1:       c.chunk_steps = 16'hFFFF;
        2:       c.chunk_steps = 16'd1;
        default: c.chunk_steps = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       c.disable_delay_ticks = 16'd0;
        1:       c.disable_delay_ticks = 16'hFFFF;
        default: c.disable_delay_ticks = 16'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 7))
        0:       c.rezero_position = 16'd0;
        1:       c.rezero_position = 16'hFFFF;
        2:       c.rezero_position = 16'($urandom_range(0, 4));
        3:       c.rezero_position = 16'($urandom);
        default: c.rezero_position = 16'($urandom_range(0, 30));
      endcase
      load_config(c);

      phase_end = cmds_sent + $urandom_range(40, 90);
      while (cmds_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            send_command(sfpc_pkg::ActSetTarget, near_target());
            if ($urandom_range(0, 3) != 0) send_command(sfpc_pkg::ActGo, 16'($urandom));
            run_ticks();
          end
          5: begin
            send_command(sfpc_pkg::ActRezero, 16'($urandom));
            run_ticks();
          end
          6: begin
            send_command($urandom_range(0, 1) ? sfpc_pkg::ActNudgeUp : sfpc_pkg::ActNudgeDown,
                         16'($urandom));
            run_ticks();
          end
          7: repeat ($urandom_range(1, 4))
               send_command(3'($urandom_range(0, 7)), 16'($urandom));
          8: begin
            send_command(sfpc_pkg::ActStop, 16'($urandom));
            run_ticks();
          end
          default: begin
            send_command(sfpc_pkg::ActGo, 16'($urandom));
            run_ticks();
          end
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stepper_focus_position_controller_unit verification clean");
    end else begin
      $display("stepper_focus_position_controller_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sfpc_pkg.sv
rtl/core/sfpc_cfg_regs.sv
rtl/core/sfpc_core.sv
rtl/core/stepper_focus_position_controller_unit.sv
tb/sv/stepper_focus_position_controller_unit_tb.sv
